### src/ttcb_pkg.sv
// Shared constants for the text terminal character buffer.
// Holds character codes, operation codes, stream field widths and default geometry.
// No dependencies.
`default_nettype none

package ttcb_pkg;

	// Default screen geometry.
	localparam int DEF_SCREEN_WIDTH  = 80;
	localparam int DEF_SCREEN_HEIGHT = 25;

	// Field widths of one request and one result.
	localparam int CHAR_W  = 8;
	localparam int COL_W   = 7;
	localparam int ROW_W   = 5;
	localparam int IN_W    = 24;
	localparam int OUT_W   = 24;

	// Operation codes carried in tuser.
	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	// Control characters.
	localparam logic [CHAR_W-1:0] CODE_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CODE_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CODE_NL    = 8'h0A;
	localparam logic [CHAR_W-1:0] CODE_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CODE_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CODE_NUL   = 8'h00;

	// Tab stops fall on multiples of this power of two.
	localparam int TAB_STOP = 4;

endpackage

`default_nettype wire

### src/text_terminal_char_buffer.sv
// Top level of the text terminal character buffer: cursor logic, row-rotated cell memory
// and the scroll/clear sequencer. Depends on ttcb_pkg.
//
// The slave channel (s_axis_*) takes one request at a time; s_axis_tuser selects a put,
// which stores or interprets the character in s_axis_tdata at the cursor, or a read of the
// cell addressed by the column and row fields. Every request gives exactly one result on
// the master channel (m_axis_*): the cell read (zero for a put), the cursor position after
// the request and a flag that is set when a put scrolled the screen up one row.
//
// A read or a non-scrolling put passes through an execute step, which computes and accesses
// the memory, and a done step, which loads the output register; the block is then ready
// again. A scrolling put only rotates the row shown on top and then fills the new bottom
// row with spaces one cell a cycle through the single write port between those two steps.
//
// After reset the cursor sits at the origin and the block writes zero to every cell, one a
// cycle, with s_axis_tready low. If the receiver stalls, the result waits in the output
// register; the next request may still be taken and then waits in its last step until the
// output register is free.
`default_nettype none

module text_terminal_char_buffer #(
	parameter int SCREEN_WIDTH  = ttcb_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = ttcb_pkg::DEF_SCREEN_HEIGHT
) (
	input  wire                        clk,
	input  wire                        arst_n,
	// Request channel.
	input  wire                        s_axis_tvalid,
	output logic                       s_axis_tready,
	// tdata, lowest bit up: char_code[7:0], cell_col[14:8], cell_row[19:15], zero fill.
	input  wire  [ttcb_pkg::IN_W-1:0]  s_axis_tdata,
	// tuser: op (0 = put, 1 = read).
	input  wire                        s_axis_tuser,
	// Result channel.
	output logic                       m_axis_tvalid,
	input  wire                        m_axis_tready,
	// tdata, lowest bit up: read_data[7:0], cursor_column[14:8], cursor_line[19:15],
	// scrolled[20], zero fill.
	output logic [ttcb_pkg::OUT_W-1:0] m_axis_tdata
);

	localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(SCREEN_WIDTH);
	localparam int RW    = $clog2(SCREEN_HEIGHT);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_EXEC   = 3'd2;
	localparam logic [2:0] ST_SCROLL = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	logic [2:0]    state_q;
	logic [AW-1:0] cnt_q;
	logic [AW-1:0] base_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [RW-1:0] top_q;
	logic          out_valid_q;
	logic [ttcb_pkg::OUT_W-1:0] out_data_q;

	// Request registers.
	logic                          op_q;
	logic [ttcb_pkg::CHAR_W-1:0]   code_q;
	logic [ttcb_pkg::COL_W-1:0]    rc_q;
	logic [ttcb_pkg::ROW_W-1:0]    rr_q;
	logic                          hit_q;
	logic                          scr_q;

	// Cell memory; physical row = (screen row + top_q) mod SCREEN_HEIGHT.
	logic [ttcb_pkg::CHAR_W-1:0] mem [CELLS];
	logic [ttcb_pkg::CHAR_W-1:0] mem_rd_q;
	logic                        mem_we;
	logic [AW-1:0]               mem_waddr;
	logic [ttcb_pkg::CHAR_W-1:0] mem_wdata;
	logic                        mem_re;
	logic [AW-1:0]               mem_raddr;

	// Put computation.
	logic [CW:0]   ncol;
	logic [RW:0]   nrow;
	logic          put_store;
	logic          put_scroll;
	logic [RW-1:0] top_next;
	logic          rd_hit;
	logic [AW-1:0] cur_addr;
	logic [AW-1:0] rd_addr;
	logic          out_free;

	function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] r,
		input logic [RW-1:0] top);
		logic [RW:0] s;
		s = {1'b0, r} + {1'b0, top};
		if (s >= (RW+1)'(SCREEN_HEIGHT)) begin
			s = s - (RW+1)'(SCREEN_HEIGHT);
		end
		return s[RW-1:0];
	endfunction

	assign s_axis_tready = (state_q == ST_IDLE);
	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	assign cur_addr = AW'(phys_row(row_q, top_q)) * AW'(SCREEN_WIDTH) + AW'(col_q);
	assign rd_addr  = AW'(phys_row(RW'(rr_q), top_q)) * AW'(SCREEN_WIDTH) + AW'(rc_q);
	assign rd_hit   = (32'(rc_q) < 32'(SCREEN_WIDTH)) && (32'(rr_q) < 32'(SCREEN_HEIGHT));
	assign top_next = (top_q == RW'(SCREEN_HEIGHT - 1)) ? '0 : top_q + RW'(1);

	// Cursor update of a put, as one step on narrow values.
	always_comb begin
		ncol      = {1'b0, col_q};
		nrow      = {1'b0, row_q};
		put_store = 1'b0;
		unique case (code_q)
			ttcb_pkg::CODE_TAB: begin
				ncol = {1'b0, col_q} + (CW+1)'(ttcb_pkg::TAB_STOP)
					- ({1'b0, col_q} & (CW+1)'(ttcb_pkg::TAB_STOP - 1));
			end
			ttcb_pkg::CODE_BS: begin
				if (col_q != '0) begin
					ncol = {1'b0, col_q} - (CW+1)'(1);
				end else if (row_q != '0) begin
					nrow = {1'b0, row_q} - (RW+1)'(1);
					ncol = (CW+1)'(SCREEN_WIDTH - 1);
				end
			end
			ttcb_pkg::CODE_CR: begin
				ncol = '0;
			end
			ttcb_pkg::CODE_NL: begin
				ncol = '0;
				nrow = {1'b0, row_q} + (RW+1)'(1);
			end
			default: begin
				put_store = 1'b1;
				ncol      = {1'b0, col_q} + (CW+1)'(1);
			end
		endcase
		if (ncol >= (CW+1)'(SCREEN_WIDTH)) begin
			ncol = '0;
			nrow = nrow + (RW+1)'(1);
		end
		put_scroll = (nrow >= (RW+1)'(SCREEN_HEIGHT));
		if (put_scroll) begin
			nrow = (RW+1)'(SCREEN_HEIGHT - 1);
		end
	end

	// Single write port shared by the reset sweep, character stores and row fills.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = ttcb_pkg::CODE_NUL;
		mem_re    = (state_q == ST_EXEC) && (op_q == ttcb_pkg::OP_READ);
		mem_raddr = rd_addr;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_EXEC: begin
				mem_we    = (op_q == ttcb_pkg::OP_PUT) && put_store;
				mem_waddr = cur_addr;
				mem_wdata = code_q;
			end
			ST_SCROLL: begin
				mem_we    = 1'b1;
				mem_waddr = base_q + cnt_q;
				mem_wdata = ttcb_pkg::CODE_SPACE;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rd_q <= mem[mem_raddr];
		end
	end

	// Request payload registers.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_q   <= s_axis_tuser;
			code_q <= s_axis_tdata[7:0];
			rc_q   <= s_axis_tdata[14:8];
			rr_q   <= s_axis_tdata[19:15];
		end
		if (state_q == ST_EXEC) begin
			hit_q  <= (op_q == ttcb_pkg::OP_READ) && rd_hit;
			scr_q  <= (op_q == ttcb_pkg::OP_PUT) && put_scroll;
			base_q <= AW'(top_q) * AW'(SCREEN_WIDTH);
		end
		if (state_q == ST_DONE && out_free) begin
			out_data_q <= {3'b000, scr_q, 5'(row_q), 7'(col_q),
				hit_q ? mem_rd_q : ttcb_pkg::CODE_NUL};
		end
	end

	// Sequencer and cursor state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			top_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result replaces the one taken in the same cycle.
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (cnt_q == AW'(CELLS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (op_q == ttcb_pkg::OP_PUT) begin
						col_q <= ncol[CW-1:0];
						row_q <= nrow[RW-1:0];
					end
					if ((op_q == ttcb_pkg::OP_PUT) && put_scroll) begin
						top_q   <= top_next;
						cnt_q   <= '0;
						state_q <= ST_SCROLL;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_SCROLL: begin
					if (cnt_q == AW'(SCREEN_WIDTH - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The cursor and the top row never leave the screen.
	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(col_q) < 32'(SCREEN_WIDTH)) && (32'(row_q) < 32'(SCREEN_HEIGHT))
		&& (32'(top_q) < 32'(SCREEN_HEIGHT)))
		else $error("cursor or top row out of range");

	// A scrolled result always leaves the cursor on the bottom row.
	a_scroll_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q[20]) |-> (out_data_q[19:15] == 5'(SCREEN_HEIGHT - 1)))
		else $error("scroll result not on bottom row");

	// A result is never overwritten while it waits for the receiver.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_data_q)))
		else $error("pending result lost");

	// The row fill stays within one row.
	a_fill_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCROLL) |-> (32'(cnt_q) < 32'(SCREEN_WIDTH)))
		else $error("row fill overran its row");

	// No request is taken during the reset sweep or a row fill.
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_CLEAR) || (state_q == ST_SCROLL)) |-> !s_axis_tready)
		else $error("ready while memory is being written");

endmodule

`default_nettype wire
